/* hw/rtl/deq_pkg.sv */
`timescale 1ns / 1ps
// shared definitions for the double-ended queue: default sizes, field widths,
// request actions and the control word that steers the row of storage cells
// no dependencies
package deq_pkg;

	// default sizing
	localparam int DEQ_CAPACITY   = 64;
	localparam int DEQ_VALUE_BITS = 32;
	localparam int DEQ_TAG_BITS   = 4;

	// fixed request field widths
	localparam int ACTION_W = 3;
	localparam int COUNT_W  = 8;
	localparam int POS_W    = 6;

	// request actions, codes six and seven are unused
	typedef enum logic [ACTION_W-1:0] {
		ACT_FILL_HEAD   = 3'd0,
		ACT_FILL_TAIL   = 3'd1,
		ACT_REMOVE_HEAD = 3'd2,
		ACT_REMOVE_TAIL = 3'd3,
		ACT_CLEAR       = 3'd4,
		ACT_READ        = 3'd5,
		ACT_SPARE_6     = 3'd6,
		ACT_SPARE_7     = 3'd7
	} deq_action_t;

	// cell storage operations
	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_SHR   = 2'd1;
	localparam logic [1:0] CELL_SHL   = 2'd2;
	localparam logic [1:0] CELL_WRITE = 2'd3;

	// control broadcast to every cell
	typedef struct packed {
		logic [1:0] op;
		logic       rd_load;
		logic       rd_shift;
	} cell_ctl_t;

endpackage

/* hw/rtl/deq_cell.sv */
`timescale 1ns / 1ps
// one storage cell of the queue: holds the entry at its position from the head
// and a read-chain register that walks entries toward cell zero
// depends on deq_pkg
module deq_cell #(
	parameter int W = deq_pkg::DEQ_VALUE_BITS + deq_pkg::DEQ_TAG_BITS
) (
	input  logic               clk,
	input  deq_pkg::cell_ctl_t ctl,
	input  logic               sel,
	input  logic [W-1:0]       wr_data,
	input  logic [W-1:0]       lower_data,
	input  logic [W-1:0]       upper_data,
	input  logic [W-1:0]       upper_rd,
	output logic [W-1:0]       entry,
	output logic [W-1:0]       rd
);
	import deq_pkg::*;

	logic [W-1:0] entry_q;
	logic [W-1:0] rd_q;

	// entry storage: shift toward tail, shift toward head, or tail write
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD:  entry_q <= entry_q;
			CELL_SHR:   entry_q <= lower_data;
			CELL_SHL:   entry_q <= upper_data;
			CELL_WRITE: begin
				if (sel) begin
					entry_q <= wr_data;
				end
			end
		endcase
	end

	// read chain: snapshot the entry, then pass toward cell zero
	always_ff @(posedge clk) begin
		if (ctl.rd_load) begin
			rd_q <= entry_q;
		end else if (ctl.rd_shift) begin
			rd_q <= upper_rd;
		end
	end

	assign entry = entry_q;
	assign rd    = rd_q;

endmodule

/* hw/rtl/double_ended_queue.sv */
`timescale 1ns / 1ps
// Bounded double-ended queue of tagged values kept in a row of cells, cell k
// holding the entry k places from the head. One request is handled at a time
// and each gives one response. An accepted request moves the cell row n times,
// then waits in the done state until the response register is free, and is
// answered as the queue returns to idle, ready to take the next request. Here
// n is the number of entries written by a fill (at most the free space), the
// number dropped from the head by a remove-head (at most the occupancy), or the
// position for a valid read; every other action has n = 0. The row moves one
// place per cycle: a head fill or head removal shifts the whole row once per
// entry, a tail fill writes one cell per cycle, and a read walks the row snapshot
// one place per cycle toward cell zero. A new request is taken while the prior
// response still waits at the output. No clearing pass follows reset.
// depends on deq_pkg and deq_cell
module double_ended_queue #(
	parameter int CAPACITY   = deq_pkg::DEQ_CAPACITY,
	parameter int VALUE_BITS = deq_pkg::DEQ_VALUE_BITS,
	parameter int TAG_BITS   = deq_pkg::DEQ_TAG_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [deq_pkg::ACTION_W-1:0]     action,
	input  logic [deq_pkg::COUNT_W-1:0]      count,
	input  logic [VALUE_BITS-1:0]            value,
	input  logic [TAG_BITS-1:0]              value_tag,
	input  logic [deq_pkg::POS_W-1:0]        position,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             ok,
	output logic [$clog2(CAPACITY+1)-1:0]    occupancy,
	output logic                             read_valid,
	output logic [VALUE_BITS-1:0]            read_value,
	output logic [TAG_BITS-1:0]              read_tag
);
	import deq_pkg::*;

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int W     = VALUE_BITS + TAG_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [ACTION_W-1:0] act_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [W-1:0]        data_q;
	logic [OCC_W-1:0]    occ_q;
	logic                pend_ok_q;
	logic                pend_rv_q;
	logic                out_valid_q;
	logic                ok_q;
	logic [OCC_W-1:0]    occupancy_q;
	logic                read_valid_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic [TAG_BITS-1:0]   read_tag_q;

	logic               accept;
	logic               pos_in;
	logic               slot_free;
	cell_ctl_t          ctl;
	logic               finish;
	logic               ok_d;
	logic [OCC_W-1:0]   occ_d;
	logic [COUNT_W-1:0] cnt_d;

	logic [W-1:0] entry_w [CAPACITY];
	logic [W-1:0] rd_w    [CAPACITY];

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign pos_in    = int'(position) < int'(occ_q);
	assign slot_free = !out_valid_q || out_ready;

	// per-request step: cell control, occupancy and counter updates
	always_comb begin
		ctl          = '{op: CELL_HOLD, rd_load: 1'b0, rd_shift: 1'b0};
		ctl.rd_load  = accept && (action == ACT_READ);
		finish       = 1'b0;
		ok_d         = pend_ok_q;
		occ_d        = occ_q;
		cnt_d        = cnt_q;
		if (state_q == S_RUN) begin
			unique case (act_q)
				ACT_FILL_HEAD, ACT_FILL_TAIL: begin
					if (cnt_q == '0) begin
						finish = 1'b1;
					end else if (occ_q == OCC_W'(CAPACITY)) begin
						finish = 1'b1;
						ok_d   = 1'b0;
					end else begin
						ctl.op = (act_q == ACT_FILL_HEAD) ? CELL_SHR : CELL_WRITE;
						occ_d  = occ_q + 1'b1;
						cnt_d  = cnt_q - 1'b1;
					end
				end
				ACT_REMOVE_HEAD: begin
					if (occ_q == '0 || cnt_q == '0) begin
						finish = 1'b1;
					end else begin
						ctl.op = CELL_SHL;
						occ_d  = occ_q - 1'b1;
						cnt_d  = cnt_q - 1'b1;
					end
				end
				ACT_REMOVE_TAIL: begin
					finish = 1'b1;
					if (int'(cnt_q) >= int'(occ_q)) begin
						occ_d = '0;
					end else begin
						occ_d = occ_q - OCC_W'(cnt_q);
					end
				end
				ACT_CLEAR: begin
					finish = 1'b1;
					occ_d  = '0;
				end
				ACT_READ: begin
					if (cnt_q == '0) begin
						finish = 1'b1;
					end else begin
						ctl.rd_shift = 1'b1;
						cnt_d        = cnt_q - 1'b1;
					end
				end
				default: begin
					finish = 1'b1;
				end
			endcase
		end
	end

	// control: state, occupancy and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			pend_ok_q <= 1'b0;
			pend_rv_q <= 1'b0;
			cnt_q     <= '0;
			act_q     <= ACT_CLEAR;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q     <= action;
						state_q   <= S_RUN;
						cnt_q     <= (action == ACT_READ) ?
							(pos_in ? COUNT_W'(position) : '0) : count;
						pend_rv_q <= (action == ACT_READ) && pos_in;
						priority case (action)
							ACT_FILL_HEAD, ACT_FILL_TAIL: pend_ok_q <= 1'b1;
							ACT_REMOVE_HEAD, ACT_REMOVE_TAIL, ACT_CLEAR:
								pend_ok_q <= (occ_q != '0);
							ACT_READ: pend_ok_q <= pos_in;
							default: pend_ok_q <= 1'b0;
						endcase
					end
				end
				S_RUN: begin
					occ_q     <= occ_d;
					cnt_q     <= cnt_d;
					pend_ok_q <= ok_d;
					if (finish) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// fill payload captured with the request
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= {value, value_tag};
		end
	end

	// response register, freed by the output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			ok_q         <= pend_ok_q;
			occupancy_q  <= occ_q;
			read_valid_q <= pend_rv_q;
			read_value_q <= pend_rv_q ? rd_w[0][W-1:TAG_BITS] : '0;
			read_tag_q   <= pend_rv_q ? rd_w[0][TAG_BITS-1:0] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign occupancy  = occupancy_q;
	assign read_valid = read_valid_q;
	assign read_value = read_value_q;
	assign read_tag   = read_tag_q;

	// row of cells, cell zero at the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [W-1:0] lower;
		logic [W-1:0] upper;
		logic [W-1:0] upper_rd;
		logic         sel;

		if (i == 0) begin : g_first
			assign lower = data_q;
		end else begin : g_mid
			assign lower = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper    = '0;
			assign upper_rd = '0;
		end else begin : g_inner
			assign upper    = entry_w[i+1];
			assign upper_rd = rd_w[i+1];
		end
		assign sel = (occ_q == OCC_W'(i));

		deq_cell #(
			.W(W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sel        (sel),
			.wr_data    (data_q),
			.lower_data (lower),
			.upper_data (upper),
			.upper_rd   (upper_rd),
			.entry      (entry_w[i]),
			.rd         (rd_w[i])
		);
	end

	// occupancy never exceeds the row
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("occupancy beyond capacity");

	// head removal never shifts an empty row
	a_shl_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && ctl.op == CELL_SHL) |-> (occ_q != '0))
		else $error("shift toward head with empty queue");

	// every fill step adds exactly one entry
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && (ctl.op == CELL_SHR || ctl.op == CELL_WRITE))
		|=> (occ_q == $past(occ_q) + 1'b1))
		else $error("fill step did not add one entry");

	// a finished request waits while the response register is held
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("response dropped while output stalled");

endmodule

/* test/double_ended_queue_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the double-ended queue: a directed table, then random
// requests, each response checked against its table entry or a cycle-free model of the deque
// depends on deq_pkg and the double_ended_queue top level
module double_ended_queue_tb;

	import deq_pkg::*;

	localparam int CAP        = DEQ_CAPACITY;
	localparam int OCC_W      = $clog2(DEQ_CAPACITY + 1);
	localparam int RANDOM_REQ = 1025;
	localparam int IDLE_LIMIT = 1500;

	typedef struct packed {
		logic                      rsp_ok;
		logic [OCC_W-1:0]          rsp_occupancy;
		logic                      rsp_read_valid;
		logic [DEQ_VALUE_BITS-1:0] rsp_read_value;
		logic [DEQ_TAG_BITS-1:0]   rsp_read_tag;
	} deq_result_t;

	typedef struct {
		deq_action_t               act;
		logic [COUNT_W-1:0]        cnt;
		logic [DEQ_VALUE_BITS-1:0] val;
		logic [DEQ_TAG_BITS-1:0]   tg;
		logic [POS_W-1:0]          pos;
		bit                        typed;
		deq_result_t               res;
	} deq_row_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      in_valid   = 1'b0;
	logic [ACTION_W-1:0]       action     = '0;
	logic [COUNT_W-1:0]        count      = '0;
	logic [DEQ_VALUE_BITS-1:0] value      = '0;
	logic [DEQ_TAG_BITS-1:0]   value_tag  = '0;
	logic [POS_W-1:0]          position   = '0;
	logic                      out_ready  = 1'b0;
	logic                      in_ready;
	logic                      out_valid;
	logic                      ok;
	logic [OCC_W-1:0]          occupancy;
	logic                      read_valid;
	logic [DEQ_VALUE_BITS-1:0] read_value;
	logic [DEQ_TAG_BITS-1:0]   read_tag;

	// model of the deque contents
	logic [DEQ_VALUE_BITS-1:0] model_value [CAP];
	logic [DEQ_TAG_BITS-1:0]   model_tag   [CAP];
	logic [POS_W-1:0]          model_head  = '0;
	logic [OCC_W-1:0]          model_count = '0;

	deq_result_t pending_results [$];
	deq_row_t    directed_rows   [$];
	deq_result_t monitor_want;
	int          error_count   = 0;
	int          response_idx  = 0;
	int          idle_cycles   = 0;
	int          sink_left     = 0;
	int unsigned sink_roll;
	bit          steady_phase  = 1'b0;

	double_ended_queue uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.count      (count),
		.value      (value),
		.value_tag  (value_tag),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.occupancy  (occupancy),
		.read_valid (read_valid),
		.read_value (read_value),
		.read_tag   (read_tag)
	);

	// clock, 8 ns period
	always #4 clk = ~clk;

	// apply one request to the model and return the response it gives
	function automatic deq_result_t predict_deque(deq_action_t act, logic [COUNT_W-1:0] cnt,
			logic [DEQ_VALUE_BITS-1:0] val, logic [DEQ_TAG_BITS-1:0] tg,
			logic [POS_W-1:0] pos);
		deq_result_t        r;
		logic [POS_W-1:0]   slot;
		logic [COUNT_W-1:0] take;
		int                 fill_i;
		r = '0;
		case (act)
			ACT_FILL_HEAD, ACT_FILL_TAIL: begin
				r.rsp_ok = 1'b1;
				for (fill_i = 0; fill_i < cnt; fill_i++) begin
					if (model_count >= CAP) begin
						r.rsp_ok = 1'b0;
						break;
					end
					if (act == ACT_FILL_HEAD) begin
						model_head = model_head - 1'b1;
						slot = model_head;
					end else begin
						slot = model_head + model_count[POS_W-1:0];
					end
					model_value[slot] = val;
					model_tag[slot]   = tg;
					model_count       = model_count + 1'b1;
				end
			end
			ACT_REMOVE_HEAD, ACT_REMOVE_TAIL: begin
				if (model_count != 0) begin
					take = (cnt < {1'b0, model_count}) ? cnt : {1'b0, model_count};
					if (act == ACT_REMOVE_HEAD)
						model_head = model_head + take[POS_W-1:0];
					model_count = model_count - take[OCC_W-1:0];
					r.rsp_ok = 1'b1;
				end
			end
			ACT_CLEAR: begin
				if (model_count != 0) begin
					model_count = '0;
					r.rsp_ok = 1'b1;
				end
			end
			ACT_READ: begin
				if ({1'b0, pos} < model_count) begin
					slot = model_head + pos;
					r.rsp_ok         = 1'b1;
					r.rsp_read_valid = 1'b1;
					r.rsp_read_value = model_value[slot];
					r.rsp_read_tag   = model_tag[slot];
				end
			end
			default: begin
			end
		endcase
		r.rsp_occupancy = model_count;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on response %0d, %s: got %0h expected %0h",
			response_idx, what, got, want);
		error_count++;
	endtask

	task automatic add_row(deq_action_t act, logic [COUNT_W-1:0] cnt,
			logic [DEQ_VALUE_BITS-1:0] val, logic [DEQ_TAG_BITS-1:0] tg,
			logic [POS_W-1:0] pos, bit typed, logic r_ok, logic [OCC_W-1:0] r_occ,
			logic r_rv, logic [DEQ_VALUE_BITS-1:0] r_val, logic [DEQ_TAG_BITS-1:0] r_tag);
		deq_row_t row;
		row.act   = act;
		row.cnt   = cnt;
		row.val   = val;
		row.tg    = tg;
		row.pos   = pos;
		row.typed = typed;
		row.res   = '{r_ok, r_occ, r_rv, r_val, r_tag};
		directed_rows.push_back(row);
	endtask

	// drive one request after a random gap, wait for it to be taken, record the response due
	task automatic send_request(deq_row_t row);
		int unsigned gap_roll;
		int          gap;
		deq_result_t predicted;
		gap_roll = $urandom_range(0, 99);
		if (steady_phase || gap_roll < 50)
			gap = 0;
		else if (gap_roll < 85)
			gap = $urandom_range(1, 3);
		else if (gap_roll < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= row.act;
		count     <= row.cnt;
		value     <= row.val;
		value_tag <= row.tg;
		position  <= row.pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = predict_deque(row.act, row.cnt, row.val, row.tg, row.pos);
		pending_results.push_back(row.typed ? row.res : predicted);
	endtask

	// random request shaped by the current fill level
	task automatic make_random_row(output deq_row_t row);
		int unsigned roll;
		int unsigned sub;
		int unsigned fill_cut;
		int unsigned free_space;
		roll       = $urandom_range(0, 99);
		sub        = $urandom_range(0, 99);
		free_space = CAP - model_count;
		fill_cut   = (model_count > 48) ? 20 : ((model_count < 12) ? 45 : 32);
		row.typed  = 1'b0;
		row.res    = '0;
		row.val    = $urandom;
		row.tg     = DEQ_TAG_BITS'($urandom_range(0, 15));
		row.pos    = POS_W'($urandom_range(0, 63));
		row.cnt    = COUNT_W'($urandom_range(0, 255));
		if (roll < fill_cut) begin
			row.act = ($urandom_range(0, 1) != 0) ? ACT_FILL_HEAD : ACT_FILL_TAIL;
			if (sub < 70)
				row.cnt = COUNT_W'($urandom_range(0, 12));
			else if (sub < 85)
				row.cnt = COUNT_W'(free_space + $urandom_range(0, 1));
		end else if (roll < fill_cut + 25) begin
			row.act = ($urandom_range(0, 1) != 0) ? ACT_REMOVE_HEAD : ACT_REMOVE_TAIL;
			if (sub < 75)
				row.cnt = COUNT_W'($urandom_range(0, 8));
			else if (sub < 88)
				row.cnt = {1'b0, model_count};
		end else if (roll < 90) begin
			row.act = ACT_READ;
			if (model_count != 0 && sub < 85)
				row.pos = POS_W'($urandom_range(0, model_count - 1));
		end else if (roll < 93) begin
			row.act = ACT_CLEAR;
		end else if (roll < 96) begin
			row.act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7;
		end else begin
			row.act = deq_action_t'($urandom_range(0, 7));
		end
	endtask

	// response side: random stalls, held open during steady phases
	always @(posedge clk) begin
		if (steady_phase) begin
			out_ready <= 1'b1;
			sink_left = 0;
		end else if (sink_left != 0) begin
			sink_left--;
		end else begin
			sink_roll = $urandom_range(0, 99);
			if (sink_roll < 55) begin
				out_ready <= 1'b1;
				sink_left = $urandom_range(0, 6);
			end else if (sink_roll < 92) begin
				out_ready <= 1'b0;
				sink_left = $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				sink_left = $urandom_range(10, 40);
			end
		end
	end

	// check each response against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("response with no request pending", 32'(occupancy), '0);
			end else begin
				monitor_want = pending_results.pop_front();
				if (ok !== monitor_want.rsp_ok)
					report_mismatch("ok", 32'(ok), 32'(monitor_want.rsp_ok));
				if (occupancy !== monitor_want.rsp_occupancy)
					report_mismatch("occupancy", 32'(occupancy),
						32'(monitor_want.rsp_occupancy));
				if (read_valid !== monitor_want.rsp_read_valid)
					report_mismatch("read_valid", 32'(read_valid),
						32'(monitor_want.rsp_read_valid));
				if (read_value !== monitor_want.rsp_read_value)
					report_mismatch("read_value", read_value, monitor_want.rsp_read_value);
				if (read_tag !== monitor_want.rsp_read_tag)
					report_mismatch("read_tag", 32'(read_tag), 32'(monitor_want.rsp_read_tag));
			end
			response_idx++;
		end
	end

	// count cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		deq_row_t row;
		int       item_idx;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table: act, count, value, tag, position, typed, ok, occ, rv, rvalue, rtag
		add_row(ACT_READ,        8'd0,   32'h0,         4'h0, 6'd0,  1, 0, 0,  0, 32'h0, 4'h0);
		add_row(ACT_REMOVE_HEAD, 8'd1,   32'h0,         4'h0, 6'd0,  1, 0, 0,  0, 32'h0, 4'h0);
		add_row(ACT_REMOVE_TAIL, 8'd255, 32'hFFFFFFFF,  4'hF, 6'd63, 1, 0, 0,  0, 32'h0, 4'h0);
		add_row(ACT_CLEAR,       8'd0,   32'h0,         4'h0, 6'd0,  1, 0, 0,  0, 32'h0, 4'h0);
		add_row(ACT_SPARE_6,     8'd5,   32'h1,         4'h1, 6'd1,  1, 0, 0,  0, 32'h0, 4'h0);
		add_row(ACT_SPARE_7,     8'd255, 32'hFFFFFFFF,  4'hF, 6'd63, 1, 0, 0,  0, 32'h0, 4'h0);
		add_row(ACT_FILL_HEAD,   8'd0,   32'h12345678,  4'h3, 6'd0,  1, 1, 0,  0, 32'h0, 4'h0);
		add_row(ACT_FILL_TAIL,   8'd3,   32'hFFFFFFFF,  4'hF, 6'd0,  1, 1, 3,  0, 32'h0, 4'h0);
		add_row(ACT_FILL_HEAD,   8'd2,   32'h0,         4'h0, 6'd0,  1, 1, 5,  0, 32'h0, 4'h0);
		add_row(ACT_READ,        8'd0,   32'h0,         4'h0, 6'd0,  1, 1, 5,  1, 32'h0, 4'h0);
		add_row(ACT_READ,        8'd0,   32'h0,         4'h0, 6'd4,  1, 1, 5,  1, 32'hFFFFFFFF, 4'hF);
		add_row(ACT_READ,        8'd0,   32'h0,         4'h0, 6'd5,  1, 0, 5,  0, 32'h0, 4'h0);
		add_row(ACT_READ,        8'd0,   32'h0,         4'h0, 6'd63, 1, 0, 5,  0, 32'h0, 4'h0);
		add_row(ACT_FILL_TAIL,   8'd255, 32'hA5A55A5A,  4'hA, 6'd0,  1, 0, 64, 0, 32'h0, 4'h0);
		add_row(ACT_FILL_HEAD,   8'd1,   32'h0,         4'h0, 6'd0,  1, 0, 64, 0, 32'h0, 4'h0);
		add_row(ACT_READ,        8'd0,   32'h0,         4'h0, 6'd63, 1, 1, 64, 1, 32'hA5A55A5A, 4'hA);
		add_row(ACT_REMOVE_HEAD, 8'd0,   32'h0,         4'h0, 6'd0,  1, 1, 64, 0, 32'h0, 4'h0);
		add_row(ACT_REMOVE_TAIL, 8'd10,  32'h0,         4'h0, 6'd0,  1, 1, 54, 0, 32'h0, 4'h0);
		add_row(ACT_REMOVE_HEAD, 8'd3,   32'h0,         4'h0, 6'd0,  1, 1, 51, 0, 32'h0, 4'h0);
		add_row(ACT_READ,        8'd0,   32'h0,         4'h0, 6'd0,  0, 0, 0,  0, 32'h0, 4'h0);
		add_row(ACT_REMOVE_HEAD, 8'd255, 32'h0,         4'h0, 6'd0,  1, 1, 0,  0, 32'h0, 4'h0);
		add_row(ACT_FILL_HEAD,   8'd255, 32'h87654321,  4'h5, 6'd0,  1, 0, 64, 0, 32'h0, 4'h0);
		add_row(ACT_CLEAR,       8'd0,   32'h0,         4'h0, 6'd0,  1, 1, 0,  0, 32'h0, 4'h0);
		add_row(ACT_FILL_TAIL,   8'd64,  32'h5A5AA5A5,  4'h6, 6'd0,  0, 0, 0,  0, 32'h0, 4'h0);
		add_row(ACT_REMOVE_TAIL, 8'd64,  32'h0,         4'h0, 6'd0,  1, 1, 0,  0, 32'h0, 4'h0);

		foreach (directed_rows[i])
			send_request(directed_rows[i]);

		// random requests, every fourth block of 150 with no idling on either side
		for (item_idx = 0; item_idx < RANDOM_REQ; item_idx++) begin
			steady_phase = ((item_idx / 150) % 4 == 2);
			make_random_row(row);
			send_request(row);
		end
		steady_phase = 1'b0;
		in_valid <= 1'b0;

		// drain, then allow for the longest request latency
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
